@@ sv/ertv_pkg.sv @@
// Package: shared constants, types and functions for the Euler rotate/translate unit.
`default_nettype none
package ertv_pkg;
  localparam int CordicSteps   = 16;
  localparam int CoordFracBits = 16;

  localparam logic [1:0] FUNC_RPY   = 2'd0;
  localparam logic [1:0] FUNC_YPR   = 2'd1;
  localparam logic [1:0] FUNC_TRANS = 2'd2;
  localparam logic [1:0] FUNC_PASS  = 2'd3;

  // Q.30 constants: 36-bit signed angles and a 34-bit signed inverse CORDIC gain
  localparam logic signed [35:0] Q30_PI      = 36'sd3373259426;
  localparam logic signed [35:0] Q30_TWO_PI  = 36'sd6746518852;
  localparam logic signed [35:0] Q30_HALF_PI = 36'sd1686629713;
  localparam logic signed [33:0] Q30_INV_GAIN = 34'sd652032874;

  typedef logic signed [35:0] ang_t;
  typedef logic signed [33:0] cs_t;

  function automatic logic signed [31:0] atan_q30(input int i);
    case (i)
      0: atan_q30 = 32'h3243F6A8;  1: atan_q30 = 32'h1DAC6705;
      2: atan_q30 = 32'h0FADBAFC;  3: atan_q30 = 32'h07F56EA6;
      4: atan_q30 = 32'h03FEAB76;  5: atan_q30 = 32'h01FFD55B;
      6: atan_q30 = 32'h00FFFAAA;  7: atan_q30 = 32'h007FFF55;
      8: atan_q30 = 32'h003FFFEA;  9: atan_q30 = 32'h001FFFFD;
      10: atan_q30 = 32'h000FFFFF; 11: atan_q30 = 32'h0007FFFF;
      12: atan_q30 = 32'h0003FFFF; 13: atan_q30 = 32'h0001FFFF;
      14: atan_q30 = 32'h0000FFFF; 15: atan_q30 = 32'h00007FFF;
      16: atan_q30 = 32'h00003FFF; 17: atan_q30 = 32'h00001FFF;
      18: atan_q30 = 32'h00000FFF; 19: atan_q30 = 32'h000007FF;
      20: atan_q30 = 32'h000003FF; 21: atan_q30 = 32'h000001FF;
      22: atan_q30 = 32'h000000FF; 23: atan_q30 = 32'h0000007F;
      24: atan_q30 = 32'h0000003F; 25: atan_q30 = 32'h0000001F;
      26: atan_q30 = 32'h0000000F; 27: atan_q30 = 32'h00000008;
      28: atan_q30 = 32'h00000004; 29: atan_q30 = 32'h00000002;
      30: atan_q30 = 32'h00000001;
      default: atan_q30 = 32'h00000000;
    endcase
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    if (v > 66'sh0_7FFF_FFFF) sat32 = 32'sh7FFF_FFFF;
    else if (v < -66'sh0_8000_0000) sat32 = 32'sh8000_0000;
    else sat32 = v[31:0];
  endfunction
endpackage
`default_nettype wire

@@ sv/euler_rotate_translate_vector_unit.sv @@
// Top level: three chained plane-rotation pipelines with translate path and output stall.
//  channel | signals                                   | dir
//  in      | in_valid in_ready func point_* arg_*      | in
//  out     | out_valid out_ready out_x out_y out_z     | out
// One item per cycle while the output is not stalled; data passes through three CORDIC plane pipelines in series.
// Whole pipeline advances when the output register is empty or being taken.
// Reset clears valid bits only; payload registers carry no reset.
// A stall freezes every stage, so nothing is lost or repeated.
`default_nettype none
module euler_rotate_translate_vector_unit #(
  parameter int CORDIC_STEPS    = ertv_pkg::CordicSteps,
  parameter int COORD_FRAC_BITS = ertv_pkg::CoordFracBits
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [1:0]         func,
  input  wire logic signed [31:0] point_x,
  input  wire logic signed [31:0] point_y,
  input  wire logic signed [31:0] point_z,
  input  wire logic signed [31:0] arg_x,
  input  wire logic signed [31:0] arg_y,
  input  wire logic signed [31:0] arg_z,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [31:0]      out_x,
  output logic signed [31:0]      out_y,
  output logic signed [31:0]      out_z
);
  localparam int AngBits = COORD_FRAC_BITS + 4;
  localparam int Lat = CORDIC_STEPS + 5;
  localparam int Depth = 3 * Lat;

  logic en;
  assign en = !out_valid || out_ready;
  assign in_ready = en;

  logic [Depth-1:0] vld;
  logic [1:0] fn [Depth];
  logic [AngBits-1:0] ang2 [Lat];
  logic [AngBits-1:0] ang3 [2*Lat];
  logic signed [31:0] tx, ty, tz;

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (en) vld <= {vld[Depth-2:0], in_valid};
  end

  logic [AngBits-1:0] a_first, a_mid, a_last;
  assign a_first = (func == ertv_pkg::FUNC_YPR) ? arg_z[AngBits-1:0] : arg_x[AngBits-1:0];
  assign a_mid   = arg_y[AngBits-1:0];
  assign a_last  = (func == ertv_pkg::FUNC_YPR) ? arg_x[AngBits-1:0] : arg_z[AngBits-1:0];

  always_ff @(posedge clk) begin
    if (en) begin
      fn[0] <= func; ang2[0] <= a_mid; ang3[0] <= a_last;
      for (int i = 1; i < Depth; i++) fn[i] <= fn[i-1];
      for (int i = 1; i < Lat; i++) ang2[i] <= ang2[i-1];
      for (int i = 1; i < 2*Lat; i++) ang3[i] <= ang3[i-1];
    end
  end

  logic byp0;
  logic [1:0] f1, f2;
  assign byp0 = func[1];
  assign f1 = fn[Lat-1];
  assign f2 = fn[2*Lat-1];

  // stage 1 plane: rpy -> (y,z); ypr -> (x,y). Pass-through lane carries the third axis.
  logic signed [31:0] s1a_in, s1b_in, s1a, s1b, s1c;
  logic signed [31:0] c1 [Lat];
  logic signed [31:0] tra [Depth];
  logic signed [31:0] trb [Depth];
  logic signed [31:0] trc [Depth];
  assign s1a_in = (func == ertv_pkg::FUNC_YPR) ? point_x : point_y;
  assign s1b_in = (func == ertv_pkg::FUNC_YPR) ? point_y : point_z;

  always_comb begin
    tx = ertv_pkg::sat32(66'(point_x) + 66'(arg_x));
    ty = ertv_pkg::sat32(66'(point_y) + 66'(arg_y));
    tz = ertv_pkg::sat32(66'(point_z) + 66'(arg_z));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c1[0] <= (func == ertv_pkg::FUNC_YPR) ? point_z : point_x;
      for (int i = 1; i < Lat; i++) c1[i] <= c1[i-1];
      tra[0] <= (func == ertv_pkg::FUNC_TRANS) ? tx : point_x;
      trb[0] <= (func == ertv_pkg::FUNC_TRANS) ? ty : point_y;
      trc[0] <= (func == ertv_pkg::FUNC_TRANS) ? tz : point_z;
      for (int i = 1; i < Depth; i++) begin
        tra[i] <= tra[i-1]; trb[i] <= trb[i-1]; trc[i] <= trc[i-1];
      end
    end
  end
  assign s1c = c1[Lat-1];

  ertv_plane #(.CORDIC_STEPS(CORDIC_STEPS), .COORD_FRAC_BITS(COORD_FRAC_BITS)) u_p1 (
    .clk(clk), .en(en), .bypass(byp0), .angle(a_first),
    .a_in(s1a_in), .b_in(s1b_in), .a_out(s1a), .b_out(s1b));

  // recover x,y,z after stage 1
  logic signed [31:0] x1, y1, z1;
  always_comb begin
    if (f1 == ertv_pkg::FUNC_YPR) begin
      x1 = s1a; y1 = s1b; z1 = s1c;
    end else begin
      x1 = s1c; y1 = s1a; z1 = s1b;
    end
  end

  // stage 2 plane: (z,x) by pitch
  logic signed [31:0] s2a, s2b, s2c;
  logic signed [31:0] c2 [Lat];
  always_ff @(posedge clk) begin
    if (en) begin
      c2[0] <= y1;
      for (int i = 1; i < Lat; i++) c2[i] <= c2[i-1];
    end
  end
  assign s2c = c2[Lat-1];

  ertv_plane #(.CORDIC_STEPS(CORDIC_STEPS), .COORD_FRAC_BITS(COORD_FRAC_BITS)) u_p2 (
    .clk(clk), .en(en), .bypass(f1[1]), .angle(ang2[Lat-1]),
    .a_in(z1), .b_in(x1), .a_out(s2a), .b_out(s2b));

  // stage 3 plane: rpy -> (x,y); ypr -> (y,z)
  logic signed [31:0] s3a_in, s3b_in, s3a, s3b, s3c;
  logic signed [31:0] c3 [Lat];
  assign s3a_in = (f2 == ertv_pkg::FUNC_YPR) ? s2c : s2b;
  assign s3b_in = (f2 == ertv_pkg::FUNC_YPR) ? s2a : s2c;
  always_ff @(posedge clk) begin
    if (en) begin
      c3[0] <= (f2 == ertv_pkg::FUNC_YPR) ? s2b : s2a;
      for (int i = 1; i < Lat; i++) c3[i] <= c3[i-1];
    end
  end
  assign s3c = c3[Lat-1];

  ertv_plane #(.CORDIC_STEPS(CORDIC_STEPS), .COORD_FRAC_BITS(COORD_FRAC_BITS)) u_p3 (
    .clk(clk), .en(en), .bypass(f2[1]), .angle(ang3[2*Lat-1]),
    .a_in(s3a_in), .b_in(s3b_in), .a_out(s3a), .b_out(s3b));

  logic [1:0] f3;
  assign f3 = fn[Depth-1];

  always_comb begin
    out_valid = vld[Depth-1];
    if (f3[1]) begin
      out_x = tra[Depth-1]; out_y = trb[Depth-1]; out_z = trc[Depth-1];
    end else if (f3 == ertv_pkg::FUNC_YPR) begin
      out_x = s3c; out_y = s3a; out_z = s3b;
    end else begin
      out_x = s3a; out_y = s3b; out_z = s3c;
    end
  end

  assert property (@(posedge clk) disable iff (rst) !en |=> $stable(vld))
    else $error("pipeline moved while stalled");
  assert property (@(posedge clk) disable iff (rst) in_ready == (!out_valid || out_ready))
    else $error("ready not tied to output drain");
  assert property (@(posedge clk) disable iff (rst) out_valid && !out_ready |=> out_valid)
    else $error("result dropped");
endmodule
`default_nettype wire

@@ sv/ertv_plane.sv @@
// Pipelined plane rotation: angle reduction, CORDIC stages, four products, rounding.
`default_nettype none
module ertv_plane #(
  parameter int CORDIC_STEPS    = ertv_pkg::CordicSteps,
  parameter int COORD_FRAC_BITS = ertv_pkg::CoordFracBits,
  localparam int AngBits = COORD_FRAC_BITS + 4,
  localparam int Lat = CORDIC_STEPS + 5
) (
  input  wire logic                clk,
  input  wire logic                en,
  input  wire logic                bypass,
  input  wire logic [AngBits-1:0]  angle,
  input  wire logic signed [31:0]  a_in,
  input  wire logic signed [31:0]  b_in,
  output logic signed [31:0]       a_out,
  output logic signed [31:0]       b_out
);
  localparam int N = CORDIC_STEPS + 1;

  // stage 0: scale and wrap
  ertv_pkg::ang_t a0;
  always_comb begin
    a0 = ertv_pkg::ang_t'($signed(angle)) <<< (30 - COORD_FRAC_BITS);
    if (a0 > ertv_pkg::Q30_PI) a0 = a0 - ertv_pkg::Q30_TWO_PI;
    if (a0 < -ertv_pkg::Q30_PI) a0 = a0 + ertv_pkg::Q30_TWO_PI;
  end

  ertv_pkg::ang_t  za [N];
  ertv_pkg::cs_t   cx [N];
  ertv_pkg::cs_t   cy [N];
  logic            ng [N];
  logic            bp [N+3];
  logic signed [31:0] pa [N+3];
  logic signed [31:0] pb [N+3];
  ertv_pkg::ang_t  a1;
  logic            ng1;

  always_comb begin
    a1 = a0;
    ng1 = 1'b0;
    if (a0 > ertv_pkg::Q30_HALF_PI) begin
      a1 = a0 - ertv_pkg::Q30_PI; ng1 = 1'b1;
    end else if (a0 < -ertv_pkg::Q30_HALF_PI) begin
      a1 = a0 + ertv_pkg::Q30_PI; ng1 = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      za[0] <= a1;
      cx[0] <= ertv_pkg::Q30_INV_GAIN;
      cy[0] <= '0;
      ng[0] <= ng1;
      bp[0] <= bypass;
      pa[0] <= a_in;
      pb[0] <= b_in;
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
    localparam int Sh = (i > 33) ? 33 : i;
    always_ff @(posedge clk) begin
      if (en) begin
        if (!za[i][35]) begin
          cx[i+1] <= cx[i] - (cy[i] >>> Sh);
          cy[i+1] <= cy[i] + (cx[i] >>> Sh);
          za[i+1] <= za[i] - ertv_pkg::ang_t'(ertv_pkg::atan_q30(i));
        end else begin
          cx[i+1] <= cx[i] + (cy[i] >>> Sh);
          cy[i+1] <= cy[i] - (cx[i] >>> Sh);
          za[i+1] <= za[i] + ertv_pkg::ang_t'(ertv_pkg::atan_q30(i));
        end
        ng[i+1] <= ng[i];
        bp[i+1] <= bp[i];
        pa[i+1] <= pa[i];
        pb[i+1] <= pb[i];
      end
    end
  end

  // sign fix, then products, then sum with rounding, then shift and saturate or pass through on bypass
  ertv_pkg::cs_t c_r, s_r;
  logic signed [65:0] m_ac, m_bs, m_as, m_bc;
  logic signed [65:0] sa, sb;
  always_ff @(posedge clk) begin
    if (en) begin
      c_r <= ng[N-1] ? -cx[N-1] : cx[N-1];
      s_r <= ng[N-1] ? -cy[N-1] : cy[N-1];
      bp[N] <= bp[N-1]; pa[N] <= pa[N-1]; pb[N] <= pb[N-1];
      m_ac <= 66'(pa[N]) * 66'(c_r);
      m_bs <= 66'(pb[N]) * 66'(s_r);
      m_as <= 66'(pa[N]) * 66'(s_r);
      m_bc <= 66'(pb[N]) * 66'(c_r);
      bp[N+1] <= bp[N]; pa[N+1] <= pa[N]; pb[N+1] <= pb[N];
      sa <= m_ac - m_bs + 66'sd536870912;
      sb <= m_as + m_bc + 66'sd536870912;
      bp[N+2] <= bp[N+1]; pa[N+2] <= pa[N+1]; pb[N+2] <= pb[N+1];
      a_out <= bp[N+2] ? pa[N+2] : ertv_pkg::sat32(sa >>> 30);
      b_out <= bp[N+2] ? pb[N+2] : ertv_pkg::sat32(sb >>> 30);
    end
  end

  logic unused;
  assign unused = (Lat != 0) & (^za[N-1]);
endmodule
`default_nettype wire

@@ tb/euler_rotate_translate_vector_unit_chk.sv @@
// Checker: predicts rotated or translated points and compares them with the unit's output.
module euler_rotate_translate_vector_unit_chk (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic [1:0]        func,
  input  logic signed [31:0] point_x,
  input  logic signed [31:0] point_y,
  input  logic signed [31:0] point_z,
  input  logic signed [31:0] arg_x,
  input  logic signed [31:0] arg_y,
  input  logic signed [31:0] arg_z,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic signed [31:0] out_x,
  input  logic signed [31:0] out_y,
  input  logic signed [31:0] out_z,
  output int                errors,
  output int                pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } point_t;

  localparam longint Pi       = 64'sd3373259426;
  localparam longint TwoPi    = 64'sd6746518852;
  localparam longint HalfPi   = 64'sd1686629713;
  localparam longint InvGain  = 64'sd652032874;
  localparam int     AngBits  = ertv_pkg::CoordFracBits + 4;

  point_t expected_points[$];

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint arctan_step(int i);
    longint tbl[32] = '{
      'h3243F6A8, 'h1DAC6705, 'h0FADBAFC, 'h07F56EA6, 'h03FEAB76, 'h01FFD55B,
      'h00FFFAAA, 'h007FFF55, 'h003FFFEA, 'h001FFFFD, 'h000FFFFF, 'h0007FFFF,
      'h0003FFFF, 'h0001FFFF, 'h0000FFFF, 'h00007FFF, 'h00003FFF, 'h00001FFF,
      'h00000FFF, 'h000007FF, 'h000003FF, 'h000001FF, 'h000000FF, 'h0000007F,
      'h0000003F, 'h0000001F, 'h0000000F, 'h00000008, 'h00000004, 'h00000002,
      'h00000001, 'h00000000};
    return tbl[i];
  endfunction

  // cosine and sine of a Q3.F angle, Q.30
  function automatic void angle_sincos(input logic [31:0] raw, output longint c,
                                       output longint s);
    longint a, x, y, nx;
    logic [AngBits-1:0] field;
    bit flip;
    field = raw[AngBits-1:0];
    a = longint'($signed(field)) * (64'sd1 <<< (30 - ertv_pkg::CoordFracBits));
    x = InvGain;
    y = 0;
    flip = 0;
    if (a > Pi) a -= TwoPi;
    if (a > Pi) a -= TwoPi;
    if (a < -Pi) a += TwoPi;
    if (a < -Pi) a += TwoPi;
    if (a > HalfPi) begin
      a -= Pi; flip = 1;
    end else if (a < -HalfPi) begin
      a += Pi; flip = 1;
    end
    for (int i = 0; i < ertv_pkg::CordicSteps && i < 32; i++) begin
      if (a >= 0) begin
        nx = x - (y >>> i); y = y + (x >>> i); a -= arctan_step(i);
      end else begin
        nx = x + (y >>> i); y = y - (x >>> i); a += arctan_step(i);
      end
      x = nx;
    end
    if (flip) begin
      x = -x; y = -y;
    end
    c = x;
    s = y;
  endfunction

  function automatic void rotate_plane(inout longint a, inout longint b,
                                       input logic [31:0] raw);
    longint c, s, na, nb;
    angle_sincos(raw, c, s);
    na = a * c - b * s;
    nb = a * s + b * c;
    a = clamp32((na + (64'sd1 <<< 29)) >>> 30);
    b = clamp32((nb + (64'sd1 <<< 29)) >>> 30);
  endfunction

  function automatic point_t transform_point(logic [1:0] f, point_t p, point_t g);
    longint x, y, z;
    point_t r;
    x = p.x; y = p.y; z = p.z;
    case (f)
      ertv_pkg::FUNC_RPY: begin
        rotate_plane(y, z, g.x); rotate_plane(z, x, g.y); rotate_plane(x, y, g.z);
      end
      ertv_pkg::FUNC_YPR: begin
        rotate_plane(x, y, g.z); rotate_plane(z, x, g.y); rotate_plane(y, z, g.x);
      end
      ertv_pkg::FUNC_TRANS: begin
        x = clamp32(x + g.x); y = clamp32(y + g.y); z = clamp32(z + g.z);
      end
      default: ;
    endcase
    r.x = x[31:0]; r.y = y[31:0]; r.z = z[31:0];
    return r;
  endfunction

  assign pending = expected_points.size();

  always @(posedge clk) begin
    point_t want;
    if (rst) begin
      errors <= 0;
    end else begin
      if (in_valid && in_ready)
        expected_points.push_back(transform_point(func, '{point_x, point_y, point_z},
                                                  '{arg_x, arg_y, arg_z}));
      if (out_valid && out_ready) begin
        if (expected_points.size() == 0) begin
          if (errors < 10) $display("unexpected result %h %h %h", out_x, out_y, out_z);
          errors <= errors + 1;
        end else begin
          want = expected_points.pop_front();
          if (want.x !== out_x || want.y !== out_y || want.z !== out_z) begin
            if (errors < 10)
              $display("mismatch: expected %h %h %h, got %h %h %h",
                       want.x, want.y, want.z, out_x, out_y, out_z);
            errors <= errors + 1;
          end
        end
      end
    end
  end
endmodule

@@ tb/euler_rotate_translate_vector_unit_tb.sv @@
// Testbench top: drives points and angles into the unit and reports the verdict.
module euler_rotate_translate_vector_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Latency = 3 * (ertv_pkg::CordicSteps + 5);
  localparam int StallLimit = 5000;

  logic clk = 0, rst = 1;
  logic in_valid = 0, in_ready, out_valid, out_ready = 0;
  logic [1:0] func = '0;
  logic signed [31:0] point_x = '0, point_y = '0, point_z = '0;
  logic signed [31:0] arg_x = '0, arg_y = '0, arg_z = '0;
  logic signed [31:0] out_x, out_y, out_z;
  int errors, pending;
  int sent = 0, idle_cycles = 0;
  bit quiet = 0, hold_off = 0;

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  euler_rotate_translate_vector_unit i_dut (.*);

  euler_rotate_translate_vector_unit_chk i_chk (.*);

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > StallLimit) begin
      $display("watchdog expired");
      $display("end of test: mismatches");
      $finish;
    end
  end

  // receiver: random stall bursts, one long hold-off
  initial begin
    int n;
    @(posedge clk iff !rst);
    forever begin
      if (hold_off) begin
        out_ready <= 0;
        repeat (200) @(posedge clk);
        hold_off = 0;
      end
      if (!quiet && $urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 14);
        out_ready <= 0;
        repeat (n) @(posedge clk);
      end
      out_ready <= 1;
      n = $urandom_range(1, 20);
      repeat (n) @(posedge clk);
    end
  end

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return 32'h7FFFFFFF;
      1: return 32'h80000000;
      2: return $urandom_range(0, 'h3FFFF) - 'h1FFFF;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_item(logic [1:0] f, logic [31:0] px, py, pz, ax, ay, az);
    func <= f; point_x <= px; point_y <= py; point_z <= pz;
    arg_x <= ax; arg_y <= ay; arg_z <= az;
    in_valid <= 1;
    @(posedge clk iff in_ready);
    sent++;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // directed: extremes, each selector, angle wrap and the ignored high bits
    send_item(ertv_pkg::FUNC_RPY, 32'h00010000, 32'h00020000, 32'h00030000, 0, 0, 0);
    send_item(ertv_pkg::FUNC_RPY, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF,
              32'h0007FFFF, 32'h00080000, 32'h0001921F);
    send_item(ertv_pkg::FUNC_YPR, 32'h80000000, 32'h80000000, 32'h80000000,
              32'h00032440, 32'hFFFCDBC0, 32'h00019220);
    send_item(ertv_pkg::FUNC_YPR, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
              32'hFFF00000, 32'hFFFFFFFF, 32'h12345678);
    send_item(ertv_pkg::FUNC_TRANS, 32'h7FFFFFFF, 32'h80000000, 32'h00000001,
              32'h00000001, 32'hFFFFFFFF, 32'hFFFFFFFF);
    send_item(ertv_pkg::FUNC_TRANS, 32'h80000000, 32'h7FFFFFFF, 0,
              32'h80000000, 32'h7FFFFFFF, 32'h80000000);
    send_item(ertv_pkg::FUNC_PASS, 32'h12345678, 32'h9ABCDEF0, 32'hFFFFFFFF,
              $urandom, $urandom, $urandom);
    send_item(ertv_pkg::FUNC_RPY, 32'h00010000, 0, 0,
              32'h00064880, 32'hFFF9B780, 32'h0006487F);
    // long receiver hold-off with the sender still offering
    hold_off = 1;
    repeat (150) send_item(2'($urandom_range(0, 3)), rand_word(), rand_word(), rand_word(),
                           rand_word(), rand_word(), rand_word());
    in_valid <= 0;
    wait (pending == 0);
    @(posedge clk);
    repeat (850) begin
      if (sent > 900) quiet = 1;
      send_item(2'($urandom_range(0, 3)), rand_word(), rand_word(), rand_word(),
                rand_word(), rand_word(), rand_word());
    end
    in_valid <= 0;
    quiet = 1;
    wait (pending == 0);
    repeat (Latency + 10) @(posedge clk);
    $display("%0d items: all selectors incl. unused, saturation edges, angle wrap,", sent);
    $display("random idle and stall bursts and a long output hold-off");
    if (errors == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end
endmodule
